FILE: rtl/versioned_snapshot_table_macros.svh
// assertion macros for the versioned snapshot table
`ifndef VERSIONED_SNAPSHOT_TABLE_MACROS_SVH
`define VERSIONED_SNAPSHOT_TABLE_MACROS_SVH

// same-cycle implication
`define VST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("versioned_snapshot_table: check failed");

// next-cycle implication
`define VST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("versioned_snapshot_table: check failed");

`endif

FILE: rtl/vst_pkg.sv
`timescale 1ns / 1ps
package vst_pkg;

	localparam int FUNC_W    = 2;
	localparam int INDEX_W   = 6;
	localparam int VALUE_W   = 32;
	localparam int SNAP_ID_W = 16;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 7;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	localparam int NUM_ENTRIES_DEF  = 64;
	localparam int MAX_VERSIONS_DEF = 16;
	localparam int SNAP_BITS_DEF    = 16;

	localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SNAP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_GET  = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STS_SAT       = 2'd3;

	typedef enum logic [3:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_DECODE,
		CS_CNT_LOAD,
		CS_SET_WAIT,
		CS_SET_COMMIT,
		CS_SRCH_ADDR,
		CS_SRCH_CMP,
		CS_GET_TAKE,
		CS_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		VSEL_LAST,
		VSEL_MID,
		VSEL_PREV
	} ver_sel_t;

	typedef struct packed {
		logic     load;
		logic     clr_en;
		logic     cnt_latch;
		ver_sel_t ver_sel;
		logic     srch_step;
		logic     set_commit;
		logic     get_take;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic is_set;
		logic is_get;
		logic idx_bad;
		logic srch_done;
		logic lo_zero;
		logic out_free;
		logic clr_last;
	} sts_t;

endpackage

FILE: rtl/versioned_snapshot_table.sv
// one item at a time; after accept: snap or bad index: decode, done; set: decode, count
// load, set wait, set commit, done; get: decode, count load, k search steps (at most 5),
// final address, take (skipped when no version qualifies), done
// input ready again in the cycle after the result is loaded; a held result stalls it
// each search step is one registered read of the version memory plus a compare
// reset: counter at one, register at 64, then version counts cleared entry by entry, input not ready
`timescale 1ns / 1ps
`include "versioned_snapshot_table_macros.svh"
module versioned_snapshot_table #(
	parameter int NUM_ENTRIES  = vst_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_VERSIONS = vst_pkg::MAX_VERSIONS_DEF,
	parameter int SNAP_BITS    = vst_pkg::SNAP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [vst_pkg::S_TDATA_W-1:0]   s_tdata,   // index, value, snap_id, zero pad
	input  logic [vst_pkg::FUNC_W-1:0]      s_tuser,   // func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [vst_pkg::M_TDATA_W-1:0]   m_tdata,   // data
	output logic [vst_pkg::STATUS_W-1:0]    m_tuser,   // status
	input  logic                            cfg_we,
	input  logic [vst_pkg::CFG_W-1:0]       cfg_wdata  // entries_in_use
);

	localparam logic [SNAP_BITS-1:0] SAT_CUR = '1;
	localparam logic [vst_pkg::DATA_W-1:0] SAT_DATA = vst_pkg::DATA_W'(SAT_CUR - 1'b1);

	vst_pkg::cmd_t cmd;
	vst_pkg::sts_t sts;

	vst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vst_datapath #(
		.NUM_ENTRIES  (NUM_ENTRIES),
		.MAX_VERSIONS (MAX_VERSIONS),
		.SNAP_BITS    (SNAP_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	`VST_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)
	`VST_ASSERT_NOW(a_sat_data, m_tvalid && m_tuser == vst_pkg::STS_SAT, m_tdata == SAT_DATA)
	`VST_ASSERT_NOW(a_error_data_zero, m_tvalid && (m_tuser == vst_pkg::STS_BAD_INDEX || m_tuser == vst_pkg::STS_FULL), m_tdata == '0)

endmodule

FILE: rtl/vst_ram.sv
`timescale 1ns / 1ps
module vst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/vst_ctrl.sv
`timescale 1ns / 1ps
module vst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  vst_pkg::sts_t sts,
	output vst_pkg::cmd_t cmd
);

	vst_pkg::ctrl_state_t state_q;
	vst_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vst_pkg::CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vst_pkg::CS_CLEAR: begin
				if (sts.clr_last) begin
					state_d = vst_pkg::CS_IDLE;
				end
			end
			vst_pkg::CS_IDLE: begin
				if (s_tvalid) begin
					state_d = vst_pkg::CS_DECODE;
				end
			end
			vst_pkg::CS_DECODE: begin
				if ((sts.is_set || sts.is_get) && !sts.idx_bad) begin
					state_d = vst_pkg::CS_CNT_LOAD;
				end else begin
					state_d = vst_pkg::CS_DONE;
				end
			end
			vst_pkg::CS_CNT_LOAD: begin
				if (sts.is_set) begin
					state_d = vst_pkg::CS_SET_WAIT;
				end else begin
					state_d = vst_pkg::CS_SRCH_ADDR;
				end
			end
			vst_pkg::CS_SET_WAIT:   state_d = vst_pkg::CS_SET_COMMIT;
			vst_pkg::CS_SET_COMMIT: state_d = vst_pkg::CS_DONE;
			vst_pkg::CS_SRCH_ADDR: begin
				if (!sts.srch_done) begin
					state_d = vst_pkg::CS_SRCH_CMP;
				end else if (sts.lo_zero) begin
					state_d = vst_pkg::CS_DONE;
				end else begin
					state_d = vst_pkg::CS_GET_TAKE;
				end
			end
			vst_pkg::CS_SRCH_CMP:   state_d = vst_pkg::CS_SRCH_ADDR;
			vst_pkg::CS_GET_TAKE:   state_d = vst_pkg::CS_DONE;
			vst_pkg::CS_DONE: begin
				if (sts.out_free) begin
					state_d = vst_pkg::CS_IDLE;
				end
			end
			default: state_d = vst_pkg::CS_CLEAR;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd = '0;
		cmd.ver_sel = vst_pkg::VSEL_LAST;
		case (state_q)
			vst_pkg::CS_CLEAR:    cmd.clr_en = 1'b1;
			vst_pkg::CS_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			vst_pkg::CS_CNT_LOAD: cmd.cnt_latch = 1'b1;
			vst_pkg::CS_SET_WAIT: cmd.ver_sel = vst_pkg::VSEL_LAST;
			vst_pkg::CS_SET_COMMIT: cmd.set_commit = 1'b1;
			vst_pkg::CS_SRCH_ADDR: begin
				if (sts.srch_done) begin
					cmd.ver_sel = vst_pkg::VSEL_PREV;
				end else begin
					cmd.ver_sel = vst_pkg::VSEL_MID;
				end
			end
			vst_pkg::CS_SRCH_CMP: cmd.srch_step = 1'b1;
			vst_pkg::CS_GET_TAKE: cmd.get_take = 1'b1;
			vst_pkg::CS_DONE:     cmd.finish = sts.out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/vst_datapath.sv
`timescale 1ns / 1ps
module vst_datapath #(
	parameter int NUM_ENTRIES  = vst_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_VERSIONS = vst_pkg::MAX_VERSIONS_DEF,
	parameter int SNAP_BITS    = vst_pkg::SNAP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vst_pkg::cmd_t                   cmd,
	output vst_pkg::sts_t                   sts,
	input  logic [vst_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [vst_pkg::FUNC_W-1:0]      s_tuser,
	input  logic                            cfg_we,
	input  logic [vst_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [vst_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [vst_pkg::STATUS_W-1:0]    m_tuser
);

	localparam int EW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int XW    = (EW > vst_pkg::INDEX_W) ? EW : vst_pkg::INDEX_W;
	localparam int XW1   = XW + 1;
	localparam int CW    = $clog2(MAX_VERSIONS + 1);
	localparam int SLOTS = NUM_ENTRIES * MAX_VERSIONS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int VW    = SNAP_BITS + vst_pkg::DATA_W;
	localparam int CMP_W = (SNAP_BITS > vst_pkg::SNAP_ID_W + 1) ? SNAP_BITS
		: vst_pkg::SNAP_ID_W + 1;
	localparam logic [XW1-1:0] NE_L = XW1'(NUM_ENTRIES);
	localparam logic [EW-1:0] CLR_LAST = EW'(NUM_ENTRIES - 1);

	// latched item
	logic [vst_pkg::FUNC_W-1:0]    func_q;
	logic [vst_pkg::INDEX_W-1:0]   idx_q;
	logic [vst_pkg::VALUE_W-1:0]   val_q;
	logic [vst_pkg::SNAP_ID_W-1:0] sid_q;

	logic [vst_pkg::CFG_W-1:0] entries_q;
	logic [SNAP_BITS-1:0]      cur_q;
	logic [EW-1:0]             clr_addr_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hi_q;
	logic [vst_pkg::DATA_W-1:0]   res_data_q;
	logic [vst_pkg::STATUS_W-1:0] res_status_q;

	logic [XW-1:0] idx_ext;
	logic [EW-1:0] entry;
	logic [AW-1:0] base;
	logic [CW-1:0] mid;
	logic [CW-1:0] last_slot;
	logic [CW-1:0] prev_slot;
	logic [CW-1:0] rd_slot;

	logic          cnt_we;
	logic [EW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic [CW-1:0] cnt_rdata;

	logic          ver_we;
	logic [AW-1:0] ver_waddr;
	logic [AW-1:0] ver_raddr;
	logic [VW-1:0] ver_rdata;
	logic [SNAP_BITS-1:0]       vtag;
	logic [vst_pkg::DATA_W-1:0] vval;

	logic overwrite;
	logic differ;
	logic full;
	logic tag_gt;
	logic sat;
	logic [vst_pkg::DATA_W-1:0]   fin_data;
	logic [vst_pkg::STATUS_W-1:0] fin_status;

	assign idx_ext = XW'(idx_q);
	assign entry   = idx_ext[EW-1:0];
	assign base    = AW'(entry) * AW'(MAX_VERSIONS);

	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign last_slot = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
	assign prev_slot = lo_q - 1'b1;

	always_comb begin
		case (cmd.ver_sel)
			vst_pkg::VSEL_MID:  rd_slot = mid;
			vst_pkg::VSEL_PREV: rd_slot = prev_slot;
			default:            rd_slot = last_slot;
		endcase
	end

	assign ver_raddr = base + AW'(rd_slot);
	assign vtag      = ver_rdata[VW-1:vst_pkg::DATA_W];
	assign vval      = ver_rdata[vst_pkg::DATA_W-1:0];

	// set decision, version read of the newest slot is valid here
	assign overwrite = (cnt_q != '0) && (vtag == cur_q);
	assign differ    = ((cnt_q == '0) ? '0 : vval) != val_q;
	assign full      = cnt_q >= CW'(MAX_VERSIONS);

	assign ver_we    = cmd.set_commit && (overwrite || (differ && !full));
	assign ver_waddr = base + AW'(overwrite ? last_slot : cnt_q);

	assign cnt_we    = cmd.clr_en || (cmd.set_commit && !overwrite && differ && !full);
	assign cnt_waddr = cmd.clr_en ? clr_addr_q : entry;
	assign cnt_wdata = cmd.clr_en ? '0 : cnt_q + 1'b1;

	assign tag_gt = CMP_W'(vtag) > (CMP_W'(sid_q) + CMP_W'(1));
	assign sat    = cur_q == '1;

	vst_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_ENTRIES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (entry),
		.rdata (cnt_rdata)
	);

	vst_ram #(
		.WIDTH(VW),
		.DEPTH(SLOTS)
	) u_ver_ram (
		.clk   (clk),
		.we    (ver_we),
		.waddr (ver_waddr),
		.wdata ({cur_q, val_q}),
		.raddr (ver_raddr),
		.rdata (ver_rdata)
	);

	always_comb begin
		fin_data   = '0;
		fin_status = vst_pkg::STS_OK;
		case (func_q)
			vst_pkg::FUNC_SNAP: begin
				fin_data   = vst_pkg::DATA_W'(cur_q - 1'b1);
				fin_status = sat ? vst_pkg::STS_SAT : vst_pkg::STS_OK;
			end
			vst_pkg::FUNC_SET, vst_pkg::FUNC_GET: begin
				if (sts.idx_bad) begin
					fin_status = vst_pkg::STS_BAD_INDEX;
				end else begin
					fin_data   = res_data_q;
					fin_status = res_status_q;
				end
			end
			default: begin
				fin_data = '0;
			end
		endcase
	end

	always_comb begin
		sts.is_set    = func_q == vst_pkg::FUNC_SET;
		sts.is_get    = func_q == vst_pkg::FUNC_GET;
		sts.idx_bad   = (vst_pkg::CFG_W'(idx_q) >= entries_q) || (XW1'(idx_q) >= NE_L);
		sts.srch_done = lo_q >= hi_q;
		sts.lo_zero   = lo_q == '0;
		sts.out_free  = !m_tvalid || m_tready;
		sts.clr_last  = clr_addr_q == CLR_LAST;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= vst_pkg::CFG_RESET;
			cur_q      <= SNAP_BITS'(1);
			clr_addr_q <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (cmd.clr_en) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.finish && func_q == vst_pkg::FUNC_SNAP && !sat) begin
				cur_q <= cur_q + 1'b1;
			end
			if (cmd.finish) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// item and search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= s_tuser;
			idx_q        <= s_tdata[5:0];
			val_q        <= s_tdata[37:6];
			sid_q        <= s_tdata[53:38];
			res_data_q   <= '0;
			res_status_q <= vst_pkg::STS_OK;
		end
		if (cmd.cnt_latch) begin
			cnt_q <= cnt_rdata;
			lo_q  <= '0;
			hi_q  <= cnt_rdata;
		end
		if (cmd.srch_step) begin
			if (tag_gt) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + 1'b1;
			end
		end
		if (cmd.set_commit && !overwrite && differ && full) begin
			res_status_q <= vst_pkg::STS_FULL;
		end
		if (cmd.get_take) begin
			res_data_q <= vval;
		end
		if (cmd.finish) begin
			m_tdata <= fin_data;
			m_tuser <= fin_status;
		end
	end

endmodule

FILE: test/versioned_snapshot_table_tb.sv
`timescale 1ns / 1ps
module versioned_snapshot_table_tb;

	localparam int NUM_E        = vst_pkg::NUM_ENTRIES_DEF;
	localparam int MAX_V        = vst_pkg::MAX_VERSIONS_DEF;
	localparam logic [15:0] SNAP_TOP = 16'hFFFF;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef struct packed {
		logic [vst_pkg::DATA_W-1:0]   data;
		logic [vst_pkg::STATUS_W-1:0] status;
	} table_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [vst_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [vst_pkg::FUNC_W-1:0]    s_tuser = vst_pkg::FUNC_SET;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [vst_pkg::M_TDATA_W-1:0] m_tdata;
	logic [vst_pkg::STATUS_W-1:0]  m_tuser;
	logic                          cfg_we = 1'b0;
	logic [vst_pkg::CFG_W-1:0]     cfg_wdata = vst_pkg::CFG_RESET;

	// predictor state
	logic [31:0]  hist_value [NUM_E][MAX_V];
	logic [15:0]  hist_tag [NUM_E][MAX_V];
	int unsigned  hist_count [NUM_E];
	logic [15:0]  snap_counter;
	logic [6:0]   entries_limit;

	table_result_t pending_results[$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;
	logic          calm = 1'b0;

	versioned_snapshot_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // index, value, snap_id, zero pad
		.s_tuser   (s_tuser),   // func
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // data
		.m_tuser   (m_tuser),   // status
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)  // entries_in_use
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic table_result_t predict_access(logic [1:0] func, logic [5:0] idx,
			logic [31:0] val, logic [15:0] sid);
		table_result_t r;
		int unsigned   cnt;
		int unsigned   lo;
		int unsigned   hi;
		int unsigned   mid;
		logic [16:0]   limit;
		logic [31:0]   last_val;
		logic [15:0]   last_tag;
		r = '0;
		if (func == vst_pkg::FUNC_SNAP) begin
			r.data = 32'(snap_counter) - 32'd1;
			if (snap_counter == SNAP_TOP) begin
				r.status = vst_pkg::STS_SAT;
			end else begin
				snap_counter = snap_counter + 16'd1;
			end
		end else if (func == vst_pkg::FUNC_SET || func == vst_pkg::FUNC_GET) begin
			if ({1'b0, idx} >= entries_limit) begin
				r.status = vst_pkg::STS_BAD_INDEX;
			end else if (func == vst_pkg::FUNC_SET) begin
				cnt = hist_count[idx];
				last_val = '0;
				last_tag = '0;
				if (cnt > 0) begin
					last_val = hist_value[idx][cnt-1];
					last_tag = hist_tag[idx][cnt-1];
				end
				if (cnt > 0 && last_tag == snap_counter) begin
					hist_value[idx][cnt-1] = val;
				end else if (last_val != val) begin
					if (cnt >= MAX_V) begin
						r.status = vst_pkg::STS_FULL;
					end else begin
						hist_tag[idx][cnt] = snap_counter;
						hist_value[idx][cnt] = val;
						hist_count[idx] = cnt + 1;
					end
				end
			end else begin
				limit = {1'b0, sid} + 17'd1;
				lo = 0;
				hi = hist_count[idx];
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if ({1'b0, hist_tag[idx][mid]} > limit)
						hi = mid;
					else
						lo = mid + 1;
				end
				if (lo > 0)
					r.data = hist_value[idx][lo-1];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : result_check
		table_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 15);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					$display("%0t unexpected item: expected none actual data %h status %0d",
						$time, m_tdata, m_tuser);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.data) begin
						mismatch_count = mismatch_count + 1;
						$display("%0t data mismatch: expected %h actual %h", $time,
							want.data, m_tdata);
					end
					if (m_tuser !== want.status) begin
						mismatch_count = mismatch_count + 1;
						$display("%0t status mismatch: expected %0d actual %0d", $time,
							want.status, m_tuser);
					end
				end
			end
		end
	end

	task automatic issue_access(logic [1:0] func, logic [5:0] idx, logic [31:0] val,
			logic [15:0] sid);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {2'b00, sid, val, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(predict_access(func, idx, val, sid));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_entries_limit(logic [6:0] lim);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		entries_limit = lim;
	endtask

	task automatic test_directed();
		write_entries_limit(7'd64);
		issue_access(vst_pkg::FUNC_SET, 6'd0, 32'h7FFF_FFFF, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd0, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd0, 32'h7FFF_FFFF, 16'hFFFF);
		issue_access(vst_pkg::FUNC_SET, 6'd0, 32'h1234_5678, 16'd0);
		issue_access(vst_pkg::FUNC_SNAP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
		issue_access(vst_pkg::FUNC_SET, 6'd0, 32'h1234_5678, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd0, 32'h8000_0000, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd0, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd0, 32'd0, 16'd1);
		issue_access(vst_pkg::FUNC_GET, 6'd0, 32'd0, 16'hFFFF);
		issue_access(vst_pkg::FUNC_SET, 6'd63, 32'hFFFF_FFFF, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd63, 32'd0, 16'hFFFF);
		issue_access(vst_pkg::FUNC_GET, 6'd62, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd63, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_SNAP, 6'd0, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd63, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd63, 32'd1, 16'd0);
		issue_access(vst_pkg::FUNC_SNAP, 6'd0, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd63, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd63, 32'd0, 16'd1);
		issue_access(vst_pkg::FUNC_GET, 6'd63, 32'd0, 16'd2);
		issue_access(vst_pkg::FUNC_GET, 6'd63, 32'd0, 16'd3);
	endtask

	task automatic test_bad_index();
		write_entries_limit(7'd1);
		issue_access(vst_pkg::FUNC_SET, 6'd1, 32'h5555_AAAA, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd63, 32'd0, 16'hFFFF);
		issue_access(vst_pkg::FUNC_SET, 6'd63, 32'hAAAA_5555, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd0, 32'hAAAA_5555, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd0, 32'd0, 16'hFFFF);
		issue_access(vst_pkg::FUNC_GET, 6'd1, 32'd0, 16'hFFFF);
		issue_access(vst_pkg::FUNC_SNAP, 6'd1, 32'd0, 16'd0);
		write_entries_limit(7'd40);
		issue_access(vst_pkg::FUNC_SET, 6'd40, 32'd7, 16'd0);
		issue_access(vst_pkg::FUNC_SET, 6'd39, 32'd7, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd39, 32'd0, 16'hFFFF);
		issue_access(vst_pkg::FUNC_GET, 6'd40, 32'd0, 16'hFFFF);
	endtask

	task automatic test_history_full();
		write_entries_limit(7'd64);
		for (int v = 1; v <= MAX_V + 2; v++) begin
			issue_access(vst_pkg::FUNC_SET, 6'd5, 32'(v), 16'd0);
			if (v == MAX_V)
				issue_access(vst_pkg::FUNC_SET, 6'd5, 32'hCAFE_0000, 16'd0);
			issue_access(vst_pkg::FUNC_SNAP, 6'd0, 32'd0, 16'd0);
		end
		issue_access(vst_pkg::FUNC_SET, 6'd5, 32'hCAFE_0000, 16'd0);
		for (int s = 0; s < MAX_V + 8; s++)
			issue_access(vst_pkg::FUNC_GET, 6'd5, 32'd0,
				16'(snap_counter - 16'(s) - 16'd1));
		issue_access(vst_pkg::FUNC_GET, 6'd5, 32'd0, 16'd0);
		issue_access(vst_pkg::FUNC_GET, 6'd5, 32'd0, 16'hFFFF);
	endtask

	task automatic random_phase(int n_items);
		int unsigned r;
		int unsigned lim;
		int unsigned base;
		int unsigned back;
		logic [1:0]  func;
		logic [5:0]  idx;
		logic [31:0] val;
		logic [15:0] sid;
		lim = entries_limit;
		base = $urandom_range(63);
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				wait_drained();
			r = $urandom_range(99);
			func = (r < 45) ? vst_pkg::FUNC_SET : (r < 65) ? vst_pkg::FUNC_SNAP
				: vst_pkg::FUNC_GET;
			r = $urandom_range(9);
			if (r < 6)
				idx = 6'((base + $urandom_range(7)) % lim);
			else if (r < 9)
				idx = 6'($urandom_range(lim - 1));
			else
				idx = 6'($urandom_range(63));
			case ($urandom_range(3))
				0: val = $urandom_range(3);
				1: begin
					r = $urandom_range(3);
					val = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
						(r == 2) ? 32'hFFFF_FFFF : 32'd0;
				end
				default: val = $urandom;
			endcase
			r = $urandom_range(9);
			if (r < 6) begin
				back = $urandom_range(20);
				sid = (snap_counter - 16'd1 > 16'(back)) ? snap_counter - 16'd1 - 16'(back)
					: 16'd0;
			end else if (r < 8) begin
				sid = 16'($urandom_range(snap_counter));
			end else if (r < 9) begin
				sid = 16'($urandom);
			end else begin
				sid = 16'hFFFF;
			end
			issue_access(func, idx, val, sid);
		end
	endtask

	task automatic test_random();
		write_entries_limit(7'd64);
		random_phase(500);
		write_entries_limit(7'd1);
		random_phase(150);
		write_entries_limit(7'd40);
		random_phase(400);
		write_entries_limit(7'($urandom_range(1, 64)));
		random_phase(400);
		write_entries_limit(7'd64);
		random_phase(150);
	endtask

	task automatic test_no_stall();
		wait_drained();
		calm = 1'b1;
		random_phase(200);
		wait_drained();
		calm = 1'b0;
	endtask

	initial begin
		for (int e = 0; e < NUM_E; e++) begin
			hist_count[e] = 0;
			for (int v = 0; v < MAX_V; v++) begin
				hist_value[e][v] = '0;
				hist_tag[e][v] = '0;
			end
		end
		snap_counter = 16'd1;
		entries_limit = vst_pkg::CFG_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_bad_index();
		test_history_full();
		test_random();
		test_no_stall();
		wait_drained();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/vst_pkg.sv
rtl/vst_ram.sv
rtl/vst_ctrl.sv
rtl/vst_datapath.sv
rtl/versioned_snapshot_table.sv
test/versioned_snapshot_table_tb.sv
